[rtl/isgs_pkg.sv]
// shared types, codes and the datapath step table of the implicit shape grid sampler
`default_nettype none

package isgs_pkg;

  // shape_mode codes
  localparam logic [2:0] MODE_CUBE   = 3'd0;
  localparam logic [2:0] MODE_SPHERE = 3'd1;
  localparam logic [2:0] MODE_TANGLE = 3'd2;
  localparam logic [2:0] MODE_HEART  = 3'd3;
  localparam logic [2:0] MODE_TORUS  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_SHAPE_MODE  = 3'd0;
  localparam logic [2:0] REG_GRID_SIDE   = 3'd1;
  localparam logic [2:0] REG_OFFSET_X    = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [2:0] REG_OFFSET_Z    = 3'd4;
  localparam logic [2:0] REG_START_INDEX = 3'd5;

  localparam int STEPW = 4;

  // multiplier operand sources
  typedef enum logic [4:0] {
    OPND_ZERO,
    OPND_ONE,
    OPND_UX,
    OPND_UY,
    OPND_UZ,
    OPND_X2,
    OPND_Y2,
    OPND_Z2,
    OPND_Z3,
    OPND_SUM,
    OPND_A,
    OPND_AH,
    OPND_AL,
    OPND_X2K,
    OPND_Y2K,
    OPND_R,
    OPND_S,
    OPND_N,
    OPND_K2000,
    OPND_K1600,
    OPND_KTANGLE
  } opnd_t;

  // what happens to the registered product
  typedef enum logic [3:0] {
    POST_NONE,
    POST_LD_X2,
    POST_LD_Y2,
    POST_LD_Z2,
    POST_LD_Z3,
    POST_LD_A2,
    POST_ACC_LOAD,
    POST_ACC_LNEG,
    POST_ACC_ADD,
    POST_ACC_SUB,
    POST_ACC_ADDHI
  } post_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    opnd_t mul_a;
    opnd_t mul_b;
    post_t post;
    logic  last;
  } ucmd_t;

  typedef struct packed {
    logic  load;
    logic  capture;
    opnd_t mul_a;
    opnd_t mul_b;
    post_t post;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       skip;
  } dp_status_t;

  function automatic ucmd_t mk(input opnd_t a, input opnd_t b, input post_t p, input logic l);
    ucmd_t c;
    c.mul_a = a;
    c.mul_b = b;
    c.post  = p;
    c.last  = l;
    return c;
  endfunction

  // one multiply issued per step; the post op of a step works on the product of the step before
  function automatic ucmd_t ucode(input logic [2:0] mode, input logic [STEPW-1:0] step);
    ucmd_t c;
    c = mk(OPND_ZERO, OPND_ZERO, POST_NONE, 1'b1);
    priority if (step == 4'd0) begin
      c = mk(OPND_UX, OPND_UX, POST_NONE, 1'b0);
    end else if (step == 4'd1) begin
      c = mk(OPND_UY, OPND_UY, POST_LD_X2, 1'b0);
    end else if (step == 4'd2) begin
      c = mk(OPND_UZ, OPND_UZ, POST_LD_Y2, 1'b0);
    end else begin
      unique case (mode)
        MODE_SPHERE: begin
          unique case (step)
            4'd3:    c = mk(OPND_N, OPND_N, POST_LD_Z2, 1'b0);
            4'd4:    c = mk(OPND_ZERO, OPND_ZERO, POST_ACC_LNEG, 1'b0);
            4'd5:    c = mk(OPND_SUM, OPND_ONE, POST_NONE, 1'b0);
            default: c = mk(OPND_ZERO, OPND_ZERO, POST_ACC_ADD, 1'b1);
          endcase
        end
        MODE_TANGLE: begin
          unique case (step)
            4'd3:    c = mk(OPND_KTANGLE, OPND_ONE, POST_LD_Z2, 1'b0);
            4'd4:    c = mk(OPND_X2, OPND_X2, POST_ACC_LOAD, 1'b0);
            4'd5:    c = mk(OPND_Y2, OPND_Y2, POST_ACC_ADD, 1'b0);
            4'd6:    c = mk(OPND_Z2, OPND_Z2, POST_ACC_ADD, 1'b0);
            4'd7:    c = mk(OPND_SUM, OPND_K2000, POST_ACC_ADD, 1'b0);
            default: c = mk(OPND_ZERO, OPND_ZERO, POST_ACC_SUB, 1'b1);
          endcase
        end
        MODE_HEART: begin
          unique case (step)
            4'd3:    c = mk(OPND_ZERO, OPND_ZERO, POST_LD_Z2, 1'b0);
            4'd4:    c = mk(OPND_Z2, OPND_UZ, POST_NONE, 1'b0);
            4'd5:    c = mk(OPND_A, OPND_A, POST_LD_Z3, 1'b0);
            4'd6:    c = mk(OPND_X2K, OPND_Z3, POST_LD_A2, 1'b0);
            4'd7:    c = mk(OPND_AH, OPND_A, POST_ACC_LNEG, 1'b0);
            4'd8:    c = mk(OPND_AL, OPND_A, POST_ACC_ADDHI, 1'b0);
            4'd9:    c = mk(OPND_Y2K, OPND_Z3, POST_ACC_ADD, 1'b0);
            default: c = mk(OPND_ZERO, OPND_ZERO, POST_ACC_SUB, 1'b1);
          endcase
        end
        MODE_TORUS: begin
          unique case (step)
            4'd3:    c = mk(OPND_ZERO, OPND_ZERO, POST_LD_Z2, 1'b0);
            4'd4:    c = mk(OPND_ZERO, OPND_ZERO, POST_NONE, 1'b0);
            4'd5:    c = mk(OPND_S, OPND_S, POST_NONE, 1'b0);
            4'd6:    c = mk(OPND_R, OPND_K1600, POST_ACC_LOAD, 1'b0);
            default: c = mk(OPND_ZERO, OPND_ZERO, POST_ACC_SUB, 1'b1);
          endcase
        end
        default: c = mk(OPND_ZERO, OPND_ZERO, POST_NONE, 1'b1);
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/isgs_ctrl.sv]
// controller: handshakes, step sequencing and result register valid
`default_nettype none

module isgs_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  isgs_pkg::dp_status_t status,
  output isgs_pkg::dp_cmd_t    cmd
);
  import isgs_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [STEPW-1:0] step;
  logic [STEPW-1:0] step_next;
  logic             out_valid_next;
  ucmd_t            uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    uc          = ucode(status.mode, step);
    state_next  = state;
    step_next   = step;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.mul_a   = OPND_ZERO;
    cmd.mul_b   = OPND_ZERO;
    cmd.post    = POST_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = status.skip ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.mul_a = uc.mul_a;
        cmd.mul_b = uc.mul_b;
        cmd.post  = uc.post;
        step_next = step + 1'b1;
        if (uc.last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // result register free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.capture | (out_valid & ~out_ready);
  end

endmodule

`default_nettype wire

[rtl/isgs_dp.sv]
// datapath: configuration registers, shared multiplier, accumulator and result registers
`default_nettype none

module isgs_dp #(
  parameter int MAX_SIDE = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  input  wire  [7:0]           cell_x,
  input  wire  [7:0]           cell_y,
  input  wire  [7:0]           cell_z,
  input  isgs_pkg::dp_cmd_t    cmd,
  output isgs_pkg::dp_status_t status,
  output logic                 inside_res,
  output logic signed [16:0]   pos_x,
  output logic signed [16:0]   pos_y,
  output logic signed [16:0]   pos_z,
  output logic [31:0]          point_index
);
  import isgs_pkg::*;

  localparam logic [8:0]         SIDE_LIMIT = 9'(MAX_SIDE);
  localparam logic signed [27:0] K_TANGLE   = 28'sd1888000;
  localparam logic signed [27:0] K_2000     = 28'sd2000;
  localparam logic signed [27:0] K_1600     = 28'sd1600;
  localparam logic [17:0]        TORUS_BIAS = 18'd300;
  localparam logic [21:0]        HEART_BIAS = 22'd1600;

  // configuration
  logic [2:0]         shape_mode;
  logic [8:0]         grid_side;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] offset_z;
  logic [31:0]        point_counter;

  // item registers
  logic [7:0]         cx;
  logic [7:0]         cy;
  logic [7:0]         cz;
  logic               in_grid;
  logic signed [9:0]  ux;
  logic signed [9:0]  uy;
  logic signed [9:0]  uz;
  logic [16:0]        x2;
  logic [16:0]        y2;
  logic [16:0]        z2;
  logic signed [25:0] z3;
  logic [40:0]        a2;

  // registered values derived from the squares
  logic [18:0]        sum;
  logic [17:0]        r;
  logic [17:0]        s;
  logic signed [21:0] a;
  logic [26:0]        x2k;
  logic [23:0]        y2k;

  logic signed [27:0] op_a;
  logic signed [27:0] op_b;
  logic signed [55:0] p;
  logic signed [63:0] pe;
  logic signed [63:0] acc;

  logic [8:0]         n;
  logic               acc_le0;
  logic               hit;
  logic               rotate;
  logic [7:0]         px;
  logic [7:0]         py;
  logic [7:0]         pz;

  assign n = (grid_side > SIDE_LIMIT) ? SIDE_LIMIT : grid_side;

  assign status.mode = shape_mode;
  assign status.skip = !(shape_mode == MODE_SPHERE || shape_mode == MODE_TANGLE ||
                         shape_mode == MODE_HEART || shape_mode == MODE_TORUS);

  function automatic logic signed [27:0] operand(input opnd_t sel);
    logic signed [27:0] v;
    unique case (sel)
      OPND_ZERO:    v = '0;
      OPND_ONE:     v = 28'sd1;
      OPND_UX:      v = 28'(ux);
      OPND_UY:      v = 28'(uy);
      OPND_UZ:      v = 28'(uz);
      OPND_X2:      v = $signed({11'b0, x2});
      OPND_Y2:      v = $signed({11'b0, y2});
      OPND_Z2:      v = $signed({11'b0, z2});
      OPND_Z3:      v = 28'(z3);
      OPND_SUM:     v = $signed({9'b0, sum});
      OPND_A:       v = 28'(a);
      OPND_AH:      v = $signed({8'b0, a2[40:21]});
      OPND_AL:      v = $signed({7'b0, a2[20:0]});
      OPND_X2K:     v = $signed({1'b0, x2k});
      OPND_Y2K:     v = $signed({4'b0, y2k});
      OPND_R:       v = $signed({10'b0, r});
      OPND_S:       v = $signed({10'b0, s});
      OPND_N:       v = $signed({19'b0, n});
      OPND_K2000:   v = K_2000;
      OPND_K1600:   v = K_1600;
      OPND_KTANGLE: v = K_TANGLE;
      default:      v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = operand(cmd.mul_a);
    op_b = operand(cmd.mul_b);
  end

  assign pe = 64'(p);

  always_ff @(posedge clk) begin
    p   <= op_a * op_b;
    sum <= 19'(x2) + 19'(y2) + 19'(z2);
    r   <= 18'(x2) + 18'(z2);
    s   <= 18'(x2) + 18'(y2) + 18'(z2) + TORUS_BIAS;
    a   <= $signed(22'({x2, 2'b00}) + 22'({y2, 3'b000}) + 22'(y2) + 22'({z2, 2'b00})
                   - HEART_BIAS);
    x2k <= 27'({x2, 10'b0}) + 27'({x2, 8'b0});
    y2k <= 24'({y2, 7'b0}) + 24'({y2, 4'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx      <= cell_x;
      cy      <= cell_y;
      cz      <= cell_z;
      // centered coordinate u = 2*index - side
      ux      <= $signed({1'b0, cell_x, 1'b0}) - $signed({1'b0, n});
      uy      <= $signed({1'b0, cell_y, 1'b0}) - $signed({1'b0, n});
      uz      <= $signed({1'b0, cell_z, 1'b0}) - $signed({1'b0, n});
      in_grid <= ({1'b0, cell_x} < n) && ({1'b0, cell_y} < n) && ({1'b0, cell_z} < n);
    end
    unique case (cmd.post)
      POST_NONE:      ;
      POST_LD_X2:     x2  <= p[16:0];
      POST_LD_Y2:     y2  <= p[16:0];
      POST_LD_Z2:     z2  <= p[16:0];
      POST_LD_Z3:     z3  <= p[25:0];
      POST_LD_A2:     a2  <= p[40:0];
      POST_ACC_LOAD:  acc <= pe;
      POST_ACC_LNEG:  acc <= -pe;
      POST_ACC_ADD:   acc <= acc + pe;
      POST_ACC_SUB:   acc <= acc - pe;
      POST_ACC_ADDHI: acc <= acc + (pe <<< 21);
      default:        ;
    endcase
  end

  assign acc_le0 = acc[63] || (acc == '0);

  always_comb begin
    unique case (shape_mode)
      MODE_CUBE:   hit = in_grid;
      MODE_SPHERE: hit = in_grid && acc_le0;
      MODE_TANGLE: hit = in_grid && acc_le0;
      MODE_HEART:  hit = in_grid && acc_le0;
      MODE_TORUS:  hit = in_grid && acc_le0;
      default:     hit = 1'b0;
    endcase
    // heart and torus come out as (y, z, x)
    rotate = (shape_mode == MODE_HEART) || (shape_mode == MODE_TORUS);
    px = rotate ? cy : cx;
    py = rotate ? cz : cy;
    pz = rotate ? cx : cz;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      inside_res  <= hit;
      pos_x       <= hit ? $signed({9'b0, px}) + 17'(offset_x) : '0;
      pos_y       <= hit ? $signed({9'b0, py}) + 17'(offset_y) : '0;
      pos_z       <= hit ? $signed({9'b0, pz}) + 17'(offset_z) : '0;
      point_index <= hit ? point_counter : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode    <= MODE_CUBE;
      grid_side     <= 9'd16;
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
      point_counter <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE_MODE:  shape_mode    <= cfg_data[2:0];
        REG_GRID_SIDE:   grid_side     <= cfg_data[8:0];
        REG_OFFSET_X:    offset_x      <= $signed(cfg_data[15:0]);
        REG_OFFSET_Y:    offset_y      <= $signed(cfg_data[15:0]);
        REG_OFFSET_Z:    offset_z      <= $signed(cfg_data[15:0]);
        REG_START_INDEX: point_counter <= cfg_data;
        default:         ;
      endcase
    end else if (cmd.capture && hit) begin
      point_counter <= point_counter + 32'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/implicit_shape_grid_sampler.sv]
// implicit shape grid sampler: per-cell inside test with running point index
// one cell in flight at a time: a new cell is taken only once the result of the last one is
//   captured; cube and reserved modes capture the result directly, the other shapes first
//   step through the shape polynomial on the single shared 28x28 multiplier
// sync active-high reset: idle, no result pending, cube mode, side 16, offsets and counter 0
`default_nettype none

module implicit_shape_grid_sampler #(
  parameter int MAX_SIDE = 256
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         cell_x,
  input  wire  [7:0]         cell_y,
  input  wire  [7:0]         cell_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               inside_res,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic [31:0]        point_index
);
  import isgs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  isgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  isgs_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .cmd         (cmd),
    .status      (status),
    .inside_res  (inside_res),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .point_index (point_index)
  );

endmodule

`default_nettype wire

[rtl/isgs_checker.sv]
// port-level assertions for the implicit shape grid sampler, bound to the top level
`default_nettype none

module isgs_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire               inside_res,
  input wire signed [16:0] pos_x,
  input wire signed [16:0] pos_y,
  input wire signed [16:0] pos_z,
  input wire [31:0]        point_index
);

  // no result may be pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res) && $stable(pos_x) &&
      $stable(pos_y) && $stable(pos_z) && $stable(point_index))
    else $error("stalled result changed");

  // an outside cell carries all-zero fields
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0 &&
      point_index == 32'd0)
    else $error("outside cell with nonzero fields");

  // one cell in flight: input closes after each transfer
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

endmodule

bind implicit_shape_grid_sampler isgs_checker u_isgs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .inside_res  (inside_res),
  .pos_x       (pos_x),
  .pos_y       (pos_y),
  .pos_z       (pos_z),
  .point_index (point_index)
);

`default_nettype wire

[tb/sv/tb_implicit_shape_grid_sampler.sv]
// testbench for the implicit shape grid sampler: directed table, random cells, inside-test predictor
`default_nettype none

module tb_implicit_shape_grid_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import isgs_pkg::*;

  localparam int SIDE_LIMIT  = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_BLOCKS = 24;
  localparam int BLOCK_CELLS = 36;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic               in_shape;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [31:0]        idx;
  } cell_res_t;

  typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  cz;
    logic        typed;
    cell_res_t   res;
  } drow_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         cell_x = '0;
  logic [7:0]         cell_y = '0;
  logic [7:0]         cell_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               inside_res;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic [31:0]        point_index;

  implicit_shape_grid_sampler #(.MAX_SIDE(SIDE_LIMIT)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .point_index(point_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers and point counter
  logic [2:0]         sh_shape = MODE_CUBE;
  logic [8:0]         sh_side = 9'd16;
  logic signed [15:0] sh_off_x = '0;
  logic signed [15:0] sh_off_y = '0;
  logic signed [15:0] sh_off_z = '0;
  logic [31:0]        sh_count = '0;

  cell_res_t pending_cells[$];
  drow_t     dir_rows[$];

  int snd_idle = 0;
  int rcv_stall = 0;
  int n_err = 0;
  int n_cells = 0;
  int n_inside = 0;
  int n_settings = 0;
  int cycle_cnt = 0;

  function automatic int eff_side();
    return (sh_side > SIDE_LIMIT) ? SIDE_LIMIT : int'(sh_side);
  endfunction

  // exact inside test on the centered coordinates, then position and point index
  function automatic cell_res_t classify_cell(input logic [7:0] cx, input logic [7:0] cy,
                                              input logic [7:0] cz);
    longint    n, ux, uy, uz, x2, y2, z2, a, z3, r, s, px, py, pz;
    logic      hit;
    cell_res_t res;
    n   = longint'(eff_side());
    res = '0;
    hit = 1'b0;
    if (cx < n && cy < n && cz < n) begin
      ux = 2 * longint'(cx) - n;
      uy = 2 * longint'(cy) - n;
      uz = 2 * longint'(cz) - n;
      x2 = ux * ux;
      y2 = uy * uy;
      z2 = uz * uz;
      case (sh_shape)
        MODE_CUBE:   hit = 1'b1;
        MODE_SPHERE: hit = (x2 + y2 + z2 <= n * n);
        MODE_TANGLE: hit = (x2 * x2 + y2 * y2 + z2 * z2 - 2000 * (x2 + y2 + z2)
                            + 1888000 <= 0);
        MODE_HEART: begin
          a   = 4 * x2 + 9 * y2 + 4 * z2 - 1600;
          z3  = z2 * uz;
          hit = (a * a * a - 1280 * x2 * z3 - 144 * y2 * z3 <= 0);
        end
        MODE_TORUS: begin
          r   = x2 + z2;
          s   = r + y2 + 300;
          hit = (s * s <= 1600 * r);
        end
        default: hit = 1'b0;
      endcase
    end
    if (hit) begin
      px = cx;
      py = cy;
      pz = cz;
      // heart and torus stand on the y axis: rotate to (y, z, x)
      if (sh_shape == MODE_HEART || sh_shape == MODE_TORUS) begin
        px = cy;
        py = cz;
        pz = cx;
      end
      res.in_shape = 1'b1;
      res.px       = 17'(px + sh_off_x);
      res.py       = 17'(py + sh_off_y);
      res.pz       = 17'(pz + sh_off_z);
      res.idx      = sh_count;
      sh_count     = sh_count + 32'd1;
    end
    return res;
  endfunction

  function automatic drow_t wr_row(input logic [2:0] idx, input logic [31:0] d);
    drow_t row;
    row         = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.data    = d;
    return row;
  endfunction

  function automatic drow_t probe_row(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z);
    drow_t row;
    row      = '0;
    row.kind = ROW_CELL;
    row.cx   = x;
    row.cy   = y;
    row.cz   = z;
    return row;
  endfunction

  function automatic drow_t typed_row(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z, input logic hit,
                                      input int px, input int py, input int pz,
                                      input logic [31:0] idx);
    drow_t row;
    row              = probe_row(x, y, z);
    row.typed        = 1'b1;
    row.res.in_shape = hit;
    row.res.px       = 17'(px);
    row.res.py       = 17'(py);
    row.res.pz       = 17'(pz);
    row.res.idx      = idx;
    return row;
  endfunction

  function automatic void add_row(input drow_t row);
    dir_rows = {dir_rows, row};
  endfunction

  function automatic logic [7:0] near_centre(input int n);
    int c;
    c = n / 2 + $urandom_range(48) - 24;
    if (c < 0) c = 0;
    if (c > n - 1) c = n - 1;
    return c[7:0];
  endfunction

  task automatic note_mismatch(input string what, input cell_res_t want, input cell_res_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected inside=%0d pos=(%0d,%0d,%0d) index=%0d",
               want.in_shape, want.px, want.py, want.pz, want.idx);
      $display("  actual   inside=%0d pos=(%0d,%0d,%0d) index=%0d",
               got.in_shape, got.px, got.py, got.pz, got.idx);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_SHAPE_MODE:  sh_shape = d[2:0];
      REG_GRID_SIDE:   sh_side = d[8:0];
      REG_OFFSET_X:    sh_off_x = d[15:0];
      REG_OFFSET_Y:    sh_off_y = d[15:0];
      REG_OFFSET_Z:    sh_off_z = d[15:0];
      REG_START_INDEX: sh_count = d;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_cell(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                           input logic use_typed, input cell_res_t typed_res);
    cell_res_t res;
    in_valid <= 1'b1;
    cell_x   <= x;
    cell_y   <= y;
    cell_z   <= z;
    do @(posedge clk); while (in_ready !== 1'b1);
    res = classify_cell(x, y, z);
    n_cells++;
    if (res.in_shape) n_inside++;
    pending_cells = {pending_cells, (use_typed ? typed_res : res)};
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk) begin : result_check
    cell_res_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {inside_res, pos_x, pos_y, pos_z, point_index};
      if (pending_cells.size() == 0) begin
        note_mismatch("result transfer with nothing expected", '0, got);
      end else begin
        want = pending_cells.pop_front();
        if (got.in_shape !== want.in_shape || got.px !== want.px || got.py !== want.py ||
            got.pz !== want.pz || got.idx !== want.idx)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_cells.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0] shape;
    logic [8:0] side;
    logic [7:0] cx, cy, cz;
    int         n, roll, phase, max_side;

    // defaults after reset: cube, side 16, zero offsets, counter 0
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 0, 0, 0, 32'd0));
    add_row(typed_row(8'd15, 8'd15, 8'd15, 1'b1, 15, 15, 15, 32'd1));
    add_row(typed_row(8'd16, 8'd0, 8'd0, 1'b0, 0, 0, 0, 32'd0));
    // extreme offsets, side above the limit clamps to 256
    add_row(wr_row(REG_OFFSET_X, 32'h0000_7FFF));
    add_row(wr_row(REG_OFFSET_Y, 32'h0000_8000));
    add_row(wr_row(REG_OFFSET_Z, 32'h0000_FFFF));
    add_row(wr_row(REG_GRID_SIDE, 32'd300));
    add_row(typed_row(8'd255, 8'd255, 8'd255, 1'b1, 33022, -32513, 254, 32'd2));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 32767, -32768, -1, 32'd3));
    // empty grid, then a one-cell grid
    add_row(wr_row(REG_GRID_SIDE, 32'd0));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b0, 0, 0, 0, 32'd0));
    add_row(wr_row(REG_GRID_SIDE, 32'd1));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 32767, -32768, -1, 32'd4));
    add_row(typed_row(8'd0, 8'd1, 8'd0, 1'b0, 0, 0, 0, 32'd0));
    // counter wraps through zero
    add_row(wr_row(REG_START_INDEX, 32'hFFFF_FFFE));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 32767, -32768, -1, 32'hFFFF_FFFE));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 32767, -32768, -1, 32'hFFFF_FFFF));
    add_row(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 32767, -32768, -1, 32'd0));
    add_row(wr_row(REG_OFFSET_X, 32'd0));
    add_row(wr_row(REG_OFFSET_Y, 32'd0));
    add_row(wr_row(REG_OFFSET_Z, 32'd0));
    // sphere: center, corner, boundary touching
    add_row(wr_row(REG_GRID_SIDE, 32'd16));
    add_row(wr_row(REG_SHAPE_MODE, 32'(MODE_SPHERE)));
    add_row(probe_row(8'd8, 8'd8, 8'd8));
    add_row(probe_row(8'd0, 8'd0, 8'd0));
    add_row(probe_row(8'd8, 8'd8, 8'd0));
    add_row(wr_row(REG_GRID_SIDE, 32'd64));
    add_row(wr_row(REG_SHAPE_MODE, 32'(MODE_TANGLE)));
    add_row(probe_row(8'd32, 8'd32, 8'd32));
    add_row(probe_row(8'd12, 8'd32, 8'd32));
    add_row(probe_row(8'd10, 8'd10, 8'd32));
    add_row(wr_row(REG_SHAPE_MODE, 32'(MODE_HEART)));
    add_row(probe_row(8'd32, 8'd32, 8'd32));
    add_row(probe_row(8'd32, 8'd32, 8'd44));
    add_row(wr_row(REG_SHAPE_MODE, 32'(MODE_TORUS)));
    add_row(probe_row(8'd32, 8'd32, 8'd32));
    add_row(probe_row(8'd44, 8'd32, 8'd32));
    // reserved shape codes select nothing
    add_row(wr_row(REG_SHAPE_MODE, 32'd5));
    add_row(typed_row(8'd32, 8'd32, 8'd32, 1'b0, 0, 0, 0, 32'd0));
    add_row(wr_row(REG_SHAPE_MODE, 32'd7));
    add_row(typed_row(8'd32, 8'd32, 8'd32, 1'b0, 0, 0, 0, 32'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        send_cell(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].cz, dir_rows[i].typed,
                  dir_rows[i].res);
      end
    end

    max_side = 0;
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      settle();
      shape = 3'(blk % 8);
      roll  = $urandom_range(9);
      if (roll == 0) side = 9'($urandom_range(511));
      else if (roll == 1) side = 9'(SIDE_LIMIT);
      else if (shape == MODE_TANGLE) side = 9'($urandom_range(110, 60));
      else if (shape == MODE_HEART || shape == MODE_TORUS) side = 9'($urandom_range(90, 40));
      else side = 9'($urandom_range(64, 1));
      if (side > max_side) max_side = side;
      write_reg(REG_SHAPE_MODE, 32'(shape));
      write_reg(REG_GRID_SIDE, 32'(side));
      write_reg(REG_OFFSET_X, $urandom_range(16'hFFFF));
      write_reg(REG_OFFSET_Y, $urandom_range(16'hFFFF));
      write_reg(REG_OFFSET_Z, $urandom_range(16'hFFFF));
      if ($urandom_range(2) == 0)
        write_reg(REG_START_INDEX, $urandom_range(1) ? $urandom
                                                     : 32'hFFFF_FFF0 + $urandom_range(15));
      n_settings++;

      phase = (blk + blk / 8) % 4;
      case (phase)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 76; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 76; end
        default: begin snd_idle = 11; rcv_stall = 11; end
      endcase

      n = eff_side();
      for (int k = 0; k < BLOCK_CELLS; k++) begin
        roll = $urandom_range(99);
        if (n == 0 || roll < 10) begin
          // anywhere in the index range, mostly off the grid for small sides
          cx = 8'($urandom_range(255));
          cy = 8'($urandom_range(255));
          cz = 8'($urandom_range(255));
        end else if (roll < 55) begin
          cx = near_centre(n);
          cy = near_centre(n);
          cz = near_centre(n);
        end else begin
          cx = 8'($urandom_range(n - 1));
          cy = 8'($urandom_range(n - 1));
          cz = 8'($urandom_range(n - 1));
        end
        send_cell(cx, cy, cz, 1'b0, '0);
      end
    end

    settle();
    snd_idle  = 0;
    rcv_stall = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d cells sent, %0d inside, over %0d random shape settings (sides up to %0d)",
             n_cells, n_inside, n_settings, max_side);
    $display("all shapes and reserved codes, extreme offsets, counter wrap, four idle mixes");
    if (n_err == 0 && pending_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_err, pending_cells.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/isgs_pkg.sv
rtl/isgs_ctrl.sv
rtl/isgs_dp.sv
rtl/implicit_shape_grid_sampler.sv
rtl/isgs_checker.sv
tb/sv/tb_implicit_shape_grid_sampler.sv
